/* sv/rpmc_pkg.sv */
// Shared types, codes and wall constants for the Prim's maze carver.
package rpmc_pkg;

    typedef logic [5:0] cell_t;
    typedef logic [1:0] dir_t;

    localparam int RAND_W     = 15;
    localparam int OUT_CNT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_CARVE   = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    localparam logic [5:0] COLS_RESET = 6'd20;
    localparam logic [4:0] ROWS_RESET = 5'd10;

    localparam dir_t DIR_LEFT  = 2'd0;
    localparam dir_t DIR_RIGHT = 2'd1;
    localparam dir_t DIR_UP    = 2'd2;
    localparam dir_t DIR_DOWN  = 2'd3;

    localparam int    VIS_BIT    = 4;
    localparam int    LISTED_BIT = 5;
    localparam cell_t CELL_RESET = 6'h0F;
    localparam cell_t VISITED    = 6'h10;
    localparam cell_t LISTED     = 6'h20;

    // wall opened in the cell itself
    function automatic logic [3:0] own_wall(input dir_t d);
        logic [3:0] w;
        case (d)
            DIR_LEFT:  w = 4'h8;
            DIR_RIGHT: w = 4'h2;
            DIR_UP:    w = 4'h1;
            default:   w = 4'h4;
        endcase
        return w;
    endfunction

    // facing wall in the neighbor
    function automatic logic [3:0] far_wall(input dir_t d);
        logic [3:0] w;
        case (d)
            DIR_LEFT:  w = 4'h2;
            DIR_RIGHT: w = 4'h8;
            DIR_UP:    w = 4'h4;
            default:   w = 4'h1;
        endcase
        return w;
    endfunction

endpackage

/* sv/random_prim_maze_carver_unit.sv */
// Randomized Prim's maze carver: cell and frontier RAMs under a sequencer.
//
// Input channel (in_valid/in_ready) takes one command per transaction:
// restart, carve one step, or query one cell. Every command returns exactly
// one result transaction on the output channel (out_valid/out_ready).
// Configuration writes (cfg_valid/cfg_ready, always ready) set the column
// and row counts; write them only while the block is idle.
// A query reads one cell. A carve picks a frontier slot by a remainder pass on
// the shared divider and reads four neighbors; if one is visited, a second pass
// picks the side, then come the wall updates and four listing read/modify/write
// pairs on the cell RAM; an empty carve skips all this. Restart sweeps the whole
// cell RAM, one cell per cycle, then seeds cell (0,0) and lists its neighbors.
// One command is worked on at a time; the next is taken once the current
// result sits in the output register.
// After reset the block runs the same sweep with in_ready low; config writes
// are taken meanwhile.
// A stalled receiver holds the result in the output register; the block
// accepts one more command and parks its result until the register frees.
module random_prim_maze_carver_unit #(
    parameter int MAX_COLS       = 32,
    parameter int MAX_ROWS       = 16,
    parameter int FRONTIER_DEPTH = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic [rpmc_pkg::RAND_W-1:0]         rand_pick,
    input  logic [rpmc_pkg::RAND_W-1:0]         rand_side,
    input  logic [4:0]                          query_x,
    input  logic [3:0]                          query_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [4:0]                          cell_col,
    output logic [3:0]                          cell_row,
    output logic [3:0]                          wall_bits,
    output logic                                cell_visited,
    output logic                                carved,
    output logic                                maze_done,
    output logic [rpmc_pkg::OUT_CNT_W-1:0]      frontier_left,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ECW   = COL_W + 1;
    localparam int ERW   = ROW_W + 1;
    localparam int XY_W  = COL_W + ROW_W;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int CA_W  = $clog2(CELLS);
    localparam int FA_W  = $clog2(FRONTIER_DEPTH);
    localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_SEED   = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_PWAIT  = 5'd3;
    localparam logic [4:0] S_FRD0   = 5'd4;
    localparam logic [4:0] S_FRD1   = 5'd5;
    localparam logic [4:0] S_FRD2   = 5'd6;
    localparam logic [4:0] S_CRD    = 5'd7;
    localparam logic [4:0] S_CCHK   = 5'd8;
    localparam logic [4:0] S_SRD    = 5'd9;
    localparam logic [4:0] S_SCHK   = 5'd10;
    localparam logic [4:0] S_SSTART = 5'd11;
    localparam logic [4:0] S_SWAIT  = 5'd12;
    localparam logic [4:0] S_CARVE  = 5'd13;
    localparam logic [4:0] S_NWR    = 5'd14;
    localparam logic [4:0] S_LRD    = 5'd15;
    localparam logic [4:0] S_LCHK   = 5'd16;
    localparam logic [4:0] S_QRD    = 5'd17;
    localparam logic [4:0] S_QCHK   = 5'd18;
    localparam logic [4:0] S_RESP   = 5'd19;

    logic [4:0]                      state_reg;
    logic                            seed_reg;
    logic [CA_W-1:0]                 clr_addr_reg;
    logic [5:0]                      cols_reg;
    logic [4:0]                      rows_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [rpmc_pkg::RAND_W-1:0]     side_reg;
    logic [4:0]                      qx_reg;
    logic [3:0]                      qy_reg;
    logic [COL_W-1:0]                cur_x_reg;
    logic [ROW_W-1:0]                cur_y_reg;
    logic [FA_W-1:0]                 slot_reg;
    rpmc_pkg::cell_t                 cur_val_reg;
    rpmc_pkg::cell_t                 nb_val_reg [4];
    logic [3:0]                      vis_mask_reg;
    rpmc_pkg::dir_t                  dir_reg;
    logic [4:0]                      res_col_reg;
    logic [3:0]                      res_row_reg;
    logic [3:0]                      res_walls_reg;
    logic                            res_vis_reg;
    logic                            res_carved_reg;
    logic                            out_valid_reg;
    logic [4:0]                      cell_col_reg;
    logic [3:0]                      cell_row_reg;
    logic [3:0]                      wall_bits_reg;
    logic                            cell_visited_reg;
    logic                            carved_reg;
    logic                            maze_done_reg;
    logic [rpmc_pkg::OUT_CNT_W-1:0]  frontier_left_reg;

    logic [ECW-1:0]        eff_cols;
    logic [ERW-1:0]        eff_rows;
    logic [ECW-1:0]        nx_w;
    logic [ERW-1:0]        ny_w;
    logic                  under;
    logic                  nbr_inb;
    logic [COL_W-1:0]      nbr_x;
    logic [ROW_W-1:0]      nbr_y;
    logic [CA_W-1:0]       nbr_addr;
    logic [CA_W-1:0]       cur_addr;
    logic                  query_in;
    logic [2:0]            nc;

    logic                  cell_we;
    logic [CA_W-1:0]       cell_waddr;
    rpmc_pkg::cell_t       cell_wdata;
    logic                  cell_re;
    logic [CA_W-1:0]       cell_raddr;
    rpmc_pkg::cell_t       cell_rdata;
    logic                  fr_we;
    logic [FA_W-1:0]       fr_waddr;
    logic [XY_W-1:0]       fr_wdata;
    logic                  fr_re;
    logic [FA_W-1:0]       fr_raddr;
    logic [XY_W-1:0]       fr_rdata;

    logic                           div_start;
    logic [rpmc_pkg::RAND_W-1:0]    div_dividend;
    logic [CNT_W-1:0]               div_divisor;
    logic                           div_done;
    logic [CNT_W-1:0]               div_rem;

    logic in_fire;
    logic out_load;

    function automatic logic [CA_W-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                  input logic [ROW_W-1:0] y);
        logic [CA_W-1:0] a;
        a = CA_W'(y) * CA_W'(MAX_COLS) + CA_W'(x);
        return a;
    endfunction

    // position of the k-th set bit of m
    function automatic rpmc_pkg::dir_t kth_set(input logic [3:0] m, input logic [1:0] k);
        logic [2:0]     seen;
        rpmc_pkg::dir_t r;
        seen = 3'd0;
        r    = rpmc_pkg::DIR_LEFT;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i])
            begin
                if (seen == {1'b0, k})
                begin
                    r = 2'(i);
                end
                seen = seen + 3'd1;
            end
        end
        return r;
    endfunction

    rpmc_ram #(.WIDTH(6), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    rpmc_ram #(.WIDTH(XY_W), .DEPTH(FRONTIER_DEPTH)) u_frontier_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    rpmc_div #(.DIVISOR_W(CNT_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // clamp the configured grid size
    always_comb
    begin
        if (cols_reg < 6'd2)
            eff_cols = ECW'(2);
        else if (int'(cols_reg) > MAX_COLS)
            eff_cols = ECW'(MAX_COLS);
        else
            eff_cols = ECW'(cols_reg);
        if (rows_reg < 5'd2)
            eff_rows = ERW'(2);
        else if (int'(rows_reg) > MAX_ROWS)
            eff_rows = ERW'(MAX_ROWS);
        else
            eff_rows = ERW'(rows_reg);
    end

    // neighbor of the current cell in direction dir_reg
    always_comb
    begin
        nx_w  = ECW'(cur_x_reg);
        ny_w  = ERW'(cur_y_reg);
        under = 1'b0;
        case (dir_reg)
            rpmc_pkg::DIR_LEFT:
            begin
                nx_w  = ECW'(cur_x_reg) - ECW'(1);
                under = (cur_x_reg == '0);
            end
            rpmc_pkg::DIR_RIGHT: nx_w = ECW'(cur_x_reg) + ECW'(1);
            rpmc_pkg::DIR_UP:
            begin
                ny_w  = ERW'(cur_y_reg) - ERW'(1);
                under = (cur_y_reg == '0);
            end
            default: ny_w = ERW'(cur_y_reg) + ERW'(1);
        endcase
    end

    assign nbr_inb  = !under && (nx_w < eff_cols) && (ny_w < eff_rows);
    assign nbr_x    = nx_w[COL_W-1:0];
    assign nbr_y    = ny_w[ROW_W-1:0];
    assign nbr_addr = cell_addr(nbr_x, nbr_y);
    assign cur_addr = cell_addr(cur_x_reg, cur_y_reg);
    assign query_in = (int'(qx_reg) < MAX_COLS) && (int'(qy_reg) < MAX_ROWS);
    assign nc       = 3'(vis_mask_reg[0]) + 3'(vis_mask_reg[1])
                    + 3'(vis_mask_reg[2]) + 3'(vis_mask_reg[3]);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    // memory ports and divider launch
    always_comb
    begin
        cell_we      = 1'b0;
        cell_waddr   = cur_addr;
        cell_wdata   = cur_val_reg;
        cell_re      = 1'b0;
        cell_raddr   = nbr_addr;
        fr_we        = 1'b0;
        fr_waddr     = slot_reg;
        fr_wdata     = fr_rdata;
        fr_re        = 1'b0;
        fr_raddr     = slot_reg;
        div_start    = 1'b0;
        div_dividend = rand_pick;
        div_divisor  = count_reg;
        unique case (state_reg) inside
            S_CLR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_addr_reg;
                cell_wdata = rpmc_pkg::CELL_RESET;
            end
            S_SEED:
            begin
                cell_we    = 1'b1;
                cell_waddr = '0;
                cell_wdata = rpmc_pkg::CELL_RESET | rpmc_pkg::VISITED;
            end
            S_IDLE:
            begin
                div_start = in_fire && (command == rpmc_pkg::CMD_CARVE) && (count_reg != '0);
            end
            S_FRD0:
            begin
                fr_re = 1'b1;
            end
            S_FRD1:
            begin
                fr_re    = 1'b1;
                fr_raddr = FA_W'(count_reg - CNT_W'(1));
            end
            S_FRD2:
            begin
                fr_we = 1'b1;
            end
            S_CRD:
            begin
                cell_re    = 1'b1;
                cell_raddr = cur_addr;
            end
            S_CCHK:
            begin
                cell_we    = 1'b1;
                cell_wdata = cell_rdata & ~rpmc_pkg::LISTED;
            end
            S_SRD, S_LRD:
            begin
                cell_re = nbr_inb;
            end
            S_SSTART:
            begin
                div_start    = (vis_mask_reg != 4'd0);
                div_dividend = side_reg;
                div_divisor  = CNT_W'(nc);
            end
            S_CARVE:
            begin
                cell_we    = 1'b1;
                cell_wdata = (cur_val_reg & ~{2'b00, rpmc_pkg::own_wall(dir_reg)})
                           | rpmc_pkg::VISITED;
            end
            S_NWR:
            begin
                cell_we    = 1'b1;
                cell_waddr = nbr_addr;
                cell_wdata = nb_val_reg[dir_reg] & ~{2'b00, rpmc_pkg::far_wall(dir_reg)};
            end
            S_LCHK:
            begin
                if (nbr_inb && !cell_rdata[rpmc_pkg::VIS_BIT]
                    && !cell_rdata[rpmc_pkg::LISTED_BIT]
                    && (count_reg < CNT_W'(FRONTIER_DEPTH)))
                begin
                    cell_we    = 1'b1;
                    cell_waddr = nbr_addr;
                    cell_wdata = cell_rdata | rpmc_pkg::LISTED;
                    fr_we      = 1'b1;
                    fr_waddr   = count_reg[FA_W-1:0];
                    fr_wdata   = {nbr_y, nbr_x};
                end
            end
            S_QRD:
            begin
                cell_re    = query_in;
                cell_raddr = cell_addr(COL_W'(qx_reg), ROW_W'(qy_reg));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            seed_reg       <= 1'b0;
            clr_addr_reg   <= '0;
            cols_reg       <= rpmc_pkg::COLS_RESET;
            rows_reg       <= rpmc_pkg::ROWS_RESET;
            count_reg      <= '0;
            dir_reg        <= rpmc_pkg::DIR_LEFT;
            vis_mask_reg   <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rpmc_pkg::CFG_COLS: cols_reg <= cfg_data[5:0];
                    rpmc_pkg::CFG_ROWS: rows_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    if (clr_addr_reg == CA_W'(CELLS - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= seed_reg ? S_SEED : S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + CA_W'(1);
                    end
                end
                S_SEED:
                begin
                    seed_reg       <= 1'b0;
                    cur_x_reg      <= '0;
                    cur_y_reg      <= '0;
                    dir_reg        <= rpmc_pkg::DIR_LEFT;
                    res_col_reg    <= 5'd0;
                    res_row_reg    <= 4'd0;
                    res_walls_reg  <= 4'hF;
                    res_vis_reg    <= 1'b1;
                    res_carved_reg <= 1'b0;
                    state_reg      <= S_LRD;
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        side_reg       <= rand_side;
                        qx_reg         <= query_x;
                        qy_reg         <= query_y;
                        res_col_reg    <= 5'd0;
                        res_row_reg    <= 4'd0;
                        res_walls_reg  <= 4'd0;
                        res_vis_reg    <= 1'b0;
                        res_carved_reg <= 1'b0;
                        case (command)
                            rpmc_pkg::CMD_RESTART:
                            begin
                                seed_reg     <= 1'b1;
                                count_reg    <= '0;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLR;
                            end
                            rpmc_pkg::CMD_CARVE:
                            begin
                                state_reg <= (count_reg != '0) ? S_PWAIT : S_RESP;
                            end
                            rpmc_pkg::CMD_QUERY:
                            begin
                                state_reg <= S_QRD;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_PWAIT:
                begin
                    if (div_done)
                    begin
                        slot_reg  <= div_rem[FA_W-1:0];
                        state_reg <= S_FRD0;
                    end
                end
                S_FRD0:
                begin
                    state_reg <= S_FRD1;
                end
                S_FRD1:
                begin
                    cur_x_reg <= fr_rdata[COL_W-1:0];
                    cur_y_reg <= fr_rdata[XY_W-1:COL_W];
                    state_reg <= S_FRD2;
                end
                S_FRD2:
                begin
                    count_reg <= count_reg - CNT_W'(1);
                    state_reg <= S_CRD;
                end
                S_CRD:
                begin
                    state_reg <= S_CCHK;
                end
                S_CCHK:
                begin
                    cur_val_reg  <= cell_rdata & ~rpmc_pkg::LISTED;
                    dir_reg      <= rpmc_pkg::DIR_LEFT;
                    vis_mask_reg <= 4'd0;
                    state_reg    <= S_SRD;
                end
                S_SRD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    nb_val_reg[dir_reg]   <= cell_rdata;
                    vis_mask_reg[dir_reg] <= nbr_inb && cell_rdata[rpmc_pkg::VIS_BIT];
                    if (dir_reg == rpmc_pkg::DIR_DOWN)
                    begin
                        state_reg <= S_SSTART;
                    end
                    else
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= S_SRD;
                    end
                end
                S_SSTART:
                begin
                    if (vis_mask_reg == 4'd0)
                    begin
                        // no visited neighbor: cell leaves the frontier unvisited
                        res_col_reg   <= 5'(cur_x_reg);
                        res_row_reg   <= 4'(cur_y_reg);
                        res_walls_reg <= cur_val_reg[3:0];
                        res_vis_reg   <= cur_val_reg[rpmc_pkg::VIS_BIT];
                        state_reg     <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT:
                begin
                    if (div_done)
                    begin
                        dir_reg   <= kth_set(vis_mask_reg, div_rem[1:0]);
                        state_reg <= S_CARVE;
                    end
                end
                S_CARVE:
                begin
                    cur_val_reg <= cell_wdata;
                    state_reg   <= S_NWR;
                end
                S_NWR:
                begin
                    res_col_reg    <= 5'(cur_x_reg);
                    res_row_reg    <= 4'(cur_y_reg);
                    res_walls_reg  <= cur_val_reg[3:0];
                    res_vis_reg    <= cur_val_reg[rpmc_pkg::VIS_BIT];
                    res_carved_reg <= 1'b1;
                    dir_reg        <= rpmc_pkg::DIR_LEFT;
                    state_reg      <= S_LRD;
                end
                S_LRD:
                begin
                    state_reg <= S_LCHK;
                end
                S_LCHK:
                begin
                    if (fr_we)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (dir_reg == rpmc_pkg::DIR_DOWN)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= S_LRD;
                    end
                end
                S_QRD:
                begin
                    state_reg <= S_QCHK;
                end
                S_QCHK:
                begin
                    res_col_reg   <= qx_reg;
                    res_row_reg   <= qy_reg;
                    res_walls_reg <= query_in ? cell_rdata[3:0] : 4'd0;
                    res_vis_reg   <= query_in && cell_rdata[rpmc_pkg::VIS_BIT];
                    state_reg     <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cell_col_reg      <= res_col_reg;
            cell_row_reg      <= res_row_reg;
            wall_bits_reg     <= res_walls_reg;
            cell_visited_reg  <= res_vis_reg;
            carved_reg        <= res_carved_reg;
            maze_done_reg     <= (count_reg == '0);
            frontier_left_reg <= rpmc_pkg::OUT_CNT_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_col      = cell_col_reg;
    assign cell_row      = cell_row_reg;
    assign wall_bits     = wall_bits_reg;
    assign cell_visited  = cell_visited_reg;
    assign carved        = carved_reg;
    assign maze_done     = maze_done_reg;
    assign frontier_left = frontier_left_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FRONTIER_DEPTH))
        else $error("frontier count beyond depth");

    a_no_rw_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_we && cell_re && (cell_waddr == cell_raddr)))
        else $error("cell RAM read and write to one address in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRD2) |-> (count_reg != '0))
        else $error("frontier pop with empty frontier");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside response state");

endmodule

/* sv/rpmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rpmc_div.sv */
// Restoring radix-2 divider returning the remainder, one bit per cycle.
module rpmc_div #(
    parameter int DIVISOR_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpmc_pkg::RAND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]       divisor,
    output logic                       done,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(rpmc_pkg::RAND_W + 1);

    logic [DIVISOR_W:0]             rem_reg;
    logic [rpmc_pkg::RAND_W-1:0]    quo_reg;
    logic [DIVISOR_W-1:0]           dsr_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [DIVISOR_W:0]             trial;

    assign trial = {rem_reg[DIVISOR_W-1:0], quo_reg[rpmc_pkg::RAND_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
            cnt_reg  <= CNT_W'(rpmc_pkg::RAND_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= trial - {1'b0, dsr_reg};
            end
            else
            begin
                rem_reg <= trial;
            end
            quo_reg <= {quo_reg[rpmc_pkg::RAND_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[DIVISOR_W-1:0];

endmodule

/* bench/testbench.sv */
// Testbench for the randomized Prim's maze carver: directed and random commands, scoreboard check.
`timescale 1ns / 100ps

module testbench;

    localparam int NCOLS    = 32;
    localparam int NROWS    = 16;
    localparam int NCELLS   = NCOLS * NROWS;
    localparam int FDEPTH   = 512;
    localparam int LIMIT    = 1500000;

    typedef struct packed {
        logic [4:0] col;
        logic [3:0] row;
        logic [3:0] walls;
        logic       vis;
        logic       carved;
        logic       done;
        logic [9:0] left;
    } cell_report_t;

    class maze_scoreboard;
        logic [5:0]   grid[NCELLS];
        int unsigned  front[FDEPTH];
        int unsigned  front_n;
        logic [5:0]   cols_reg;
        logic [4:0]   rows_reg;
        cell_report_t pending[$];
        int           errors;

        function new();
            foreach (grid[i]) grid[i] = rpmc_pkg::CELL_RESET;
            front_n  = 0;
            cols_reg = rpmc_pkg::COLS_RESET;
            rows_reg = rpmc_pkg::ROWS_RESET;
            errors   = 0;
        endfunction

        function int span_x();
            if (cols_reg < 2) return 2;
            if (cols_reg > NCOLS) return NCOLS;
            return int'(cols_reg);
        endfunction

        function int span_y();
            if (rows_reg < 2) return 2;
            if (rows_reg > NROWS) return NROWS;
            return int'(rows_reg);
        endfunction

        function int adjacent(int x, int y, int d);
            int nx;
            int ny;
            nx = x + (d == rpmc_pkg::DIR_LEFT ? -1 : d == rpmc_pkg::DIR_RIGHT ? 1 : 0);
            ny = y + (d == rpmc_pkg::DIR_UP ? -1 : d == rpmc_pkg::DIR_DOWN ? 1 : 0);
            if (nx < 0 || ny < 0 || nx >= span_x() || ny >= span_y()) return -1;
            return ny * NCOLS + nx;
        endfunction

        function void enlist(int x, int y);
            int n;
            for (int d = 0; d < 4; d++)
            begin
                n = adjacent(x, y, d);
                if (n < 0) continue;
                if (grid[n][rpmc_pkg::VIS_BIT] || grid[n][rpmc_pkg::LISTED_BIT]) continue;
                if (front_n >= FDEPTH) continue;
                front[front_n] = unsigned'(n);
                front_n++;
                grid[n][rpmc_pkg::LISTED_BIT] = 1'b1;
            end
        endfunction

        function logic [3:0] opening(int d, bit own);
            case (d)
                rpmc_pkg::DIR_LEFT:  return own ? 4'h8 : 4'h2;
                rpmc_pkg::DIR_RIGHT: return own ? 4'h2 : 4'h8;
                rpmc_pkg::DIR_UP:    return own ? 4'h1 : 4'h4;
                default:             return own ? 4'h4 : 4'h1;
            endcase
        endfunction

        function void note_command(logic [1:0] cmd, logic [14:0] pick, logic [14:0] side,
                                   logic [4:0] qx, logic [3:0] qy);
            cell_report_t r;
            int slot;
            int cur;
            int x;
            int y;
            int nc;
            int dd;
            int n;
            int cand[4];
            r = '0;
            if (cmd == rpmc_pkg::CMD_RESTART)
            begin
                foreach (grid[i]) grid[i] = rpmc_pkg::CELL_RESET;
                front_n = 0;
                grid[0] = rpmc_pkg::CELL_RESET | rpmc_pkg::VISITED;
                enlist(0, 0);
                r.walls = 4'hF;
                r.vis   = 1'b1;
            end
            else if (cmd == rpmc_pkg::CMD_CARVE)
            begin
                if (front_n > 0)
                begin
                    slot = int'(pick % front_n);
                    cur  = int'(front[slot] % NCELLS);
                    x = cur % NCOLS;
                    y = cur / NCOLS;
                    front_n--;
                    front[slot] = front[front_n];
                    grid[cur][rpmc_pkg::LISTED_BIT] = 1'b0;
                    nc = 0;
                    for (int d = 0; d < 4; d++)
                    begin
                        n = adjacent(x, y, d);
                        if (n >= 0 && grid[n][rpmc_pkg::VIS_BIT])
                        begin
                            cand[nc] = d;
                            nc++;
                        end
                    end
                    if (nc > 0)
                    begin
                        dd = cand[int'(side) % nc];
                        n  = adjacent(x, y, dd);
                        grid[cur][3:0] = grid[cur][3:0] & ~opening(dd, 1'b1);
                        grid[n][3:0]   = grid[n][3:0] & ~opening(dd, 1'b0);
                        grid[cur][rpmc_pkg::VIS_BIT] = 1'b1;
                        r.carved = 1'b1;
                        enlist(x, y);
                    end
                    r.col   = 5'(x);
                    r.row   = 4'(y);
                    r.walls = grid[cur][3:0];
                    r.vis   = grid[cur][rpmc_pkg::VIS_BIT];
                end
            end
            else if (cmd == rpmc_pkg::CMD_QUERY)
            begin
                r.col   = qx;
                r.row   = qy;
                r.walls = grid[int'(qy) * NCOLS + int'(qx)][3:0];
                r.vis   = grid[int'(qy) * NCOLS + int'(qx)][rpmc_pkg::VIS_BIT];
            end
            r.done = (front_n == 0);
            r.left = 10'(front_n);
            pending.push_back(r);
        endfunction

        task check_report(cell_report_t got);
            cell_report_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, longint'(got));
                return;
            end
            want = pending.pop_front();
            if (got.col != want.col) report_mismatch("cell_col", want.col, got.col);
            if (got.row != want.row) report_mismatch("cell_row", want.row, got.row);
            if (got.walls != want.walls) report_mismatch("wall_bits", want.walls, got.walls);
            if (got.vis != want.vis) report_mismatch("cell_visited", want.vis, got.vis);
            if (got.carved != want.carved) report_mismatch("carved", want.carved, got.carved);
            if (got.done != want.done) report_mismatch("maze_done", want.done, got.done);
            if (got.left != want.left) report_mismatch("frontier_left", want.left, got.left);
        endtask

        task report_mismatch(string what, longint exp_v, longint got_v);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [14:0] rand_pick;
    logic [14:0] rand_side;
    logic [4:0]  query_x;
    logic [3:0]  query_y;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  cell_col;
    logic [3:0]  cell_row;
    logic [3:0]  wall_bits;
    logic        cell_visited;
    logic        carved;
    logic        maze_done;
    logic [9:0]  frontier_left;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    maze_scoreboard board;
    int unsigned    cycles;
    int             burst_left;
    int             stall_mode;

    random_prim_maze_carver_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .rand_pick(rand_pick), .rand_side(rand_side),
        .query_x(query_x), .query_y(query_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_col(cell_col), .cell_row(cell_row), .wall_bits(wall_bits),
        .cell_visited(cell_visited), .carved(carved), .maze_done(maze_done),
        .frontier_left(frontier_left),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial board = new();

    // receiver: stall pattern changes mode now and then
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_report({cell_col, cell_row, wall_bits, cell_visited, carved,
                                maze_done, frontier_left});
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cycles[4:3] != 2'b11);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // in_valid drops after each transaction; the block is busy then anyway
    task automatic send_command(logic [1:0] cmd, logic [14:0] pick, logic [14:0] side,
                                logic [4:0] qx, logic [3:0] qy);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        else
        begin
            @(posedge clk);
        end
        burst_left--;
        in_valid  <= 1'b1;
        command   <= cmd;
        rand_pick <= pick;
        rand_side <= side;
        query_x   <= qx;
        query_y   <= qy;
        do @(posedge clk); while (!in_ready);
        board.note_command(cmd, pick, side, qx, qy);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rpmc_pkg::CFG_COLS) board.cols_reg = val;
        else board.rows_reg = val[4:0];
        @(posedge clk);
    endtask

    task automatic carve_run(int count, int pct_carve);
        int          r;
        logic [14:0] p;
        logic [14:0] s;
        logic [4:0]  qx;
        logic [3:0]  qy;
        for (int i = 0; i < count; i++)
        begin
            r  = $urandom_range(0, 99);
            p  = 15'($urandom);
            s  = 15'($urandom);
            qx = 5'($urandom);
            qy = 4'($urandom);
            if (r < pct_carve)
                send_command(rpmc_pkg::CMD_CARVE, p, s, qx, qy);
            else if (r < 98)
                send_command(rpmc_pkg::CMD_QUERY, p, s, qx, qy);
            else if (r == 98)
                send_command(rpmc_pkg::CMD_RESTART, p, s, qx, qy);
            else
                send_command(2'd3, p, s, qx, qy);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; command = '0; rand_pick = '0; rand_side = '0;
        query_x = '0; query_y = '0; out_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        cycles = 0; burst_left = 0; stall_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty frontier, odd command, queries at corners
        send_command(rpmc_pkg::CMD_CARVE, 15'h7FFF, 15'h7FFF, 5'd0, 4'd0);
        send_command(2'd3, 15'h0, 15'h0, 5'd31, 4'd15);
        send_command(rpmc_pkg::CMD_QUERY, 15'h0, 15'h0, 5'd31, 4'd15);
        send_command(rpmc_pkg::CMD_QUERY, 15'h0, 15'h0, 5'd0, 4'd0);
        send_command(rpmc_pkg::CMD_RESTART, 15'h0, 15'h0, 5'd0, 4'd0);
        send_command(rpmc_pkg::CMD_CARVE, 15'h7FFF, 15'h7FFF, 5'd0, 4'd0);
        send_command(rpmc_pkg::CMD_CARVE, 15'h0, 15'h0, 5'd0, 4'd0);
        send_command(rpmc_pkg::CMD_QUERY, 15'h0, 15'h0, 5'd1, 4'd0);
        send_command(2'd3, 15'h7FFF, 15'h7FFF, 5'd31, 4'd15);
        drain();

        // smallest grid, run to completion and beyond
        write_reg(rpmc_pkg::CFG_COLS, 6'd0);
        write_reg(rpmc_pkg::CFG_ROWS, 6'd1);
        send_command(rpmc_pkg::CMD_RESTART, 15'd0, 15'd0, 5'd0, 4'd0);
        repeat (5)
            send_command(rpmc_pkg::CMD_CARVE, 15'($urandom), 15'($urandom), 5'd0, 4'd0);
        send_command(rpmc_pkg::CMD_QUERY, 15'd0, 15'd0, 5'd1, 4'd1);
        drain();

        // out of range high, then shrink without restart so cells lose neighbours
        write_reg(rpmc_pkg::CFG_COLS, 6'd63);
        write_reg(rpmc_pkg::CFG_ROWS, 6'd31);
        send_command(rpmc_pkg::CMD_RESTART, 15'd0, 15'd0, 5'd0, 4'd0);
        carve_run(150, 85);
        drain();
        write_reg(rpmc_pkg::CFG_COLS, 6'd3);
        write_reg(rpmc_pkg::CFG_ROWS, 6'd2);
        carve_run(60, 85);
        drain();

        // random sizes, mostly small, full builds with queries
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(rpmc_pkg::CFG_COLS, 6'($urandom_range(2, 10)));
            write_reg(rpmc_pkg::CFG_ROWS, 6'($urandom_range(2, 8)));
            send_command(rpmc_pkg::CMD_RESTART, 15'd0, 15'd0, 5'd0, 4'd0);
            carve_run(95, 70);
            drain();
        end
        write_reg(rpmc_pkg::CFG_COLS, 6'd32);
        write_reg(rpmc_pkg::CFG_ROWS, 6'd16);
        send_command(rpmc_pkg::CMD_RESTART, 15'd0, 15'd0, 5'd0, 4'd0);
        carve_run(120, 80);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* files.f */
sv/rpmc_pkg.sv
sv/rpmc_ram.sv
sv/rpmc_div.sv
sv/random_prim_maze_carver_unit.sv
bench/testbench.sv
